>>> hdl/ptb_pkg.sv
package ptb_pkg;

  localparam int unsigned TONE_BITS_DEF = 13;
  localparam int unsigned PWM_W         = 16;
  localparam int unsigned VOL_W         = 8;
  localparam int unsigned LEN_W         = 8;
  localparam int unsigned PRIO_W        = 3;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [PWM_W-1:0] PERIOD_RESET  = 16'd1024;
  localparam logic [PWM_W-1:0] COMPARE_RESET = 16'd512;
  localparam logic [VOL_W-1:0] VOLUME_RESET  = 8'd2;
  localparam logic [VOL_W-1:0] VOLUME_FIXED  = 8'd2;
  // tone is scaled by eight to form the pwm top
  localparam int unsigned      TONE_SHIFT    = 3;
  // compare shift is this base minus the zero-based volume
  localparam logic [2:0]       SHIFT_BASE    = 3'd5;
  localparam logic [VOL_W-1:0] VOLUME_MAX    = 8'd2;

  typedef enum logic [2:0] {
    OP_PLAY       = 3'd0,
    OP_PAUSE      = 3'd1,
    OP_STOP       = 3'd2,
    OP_MS_TICK    = 3'd3,
    OP_TIMER_TICK = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_UI    = 2'd0,
    KIND_ALARM = 2'd1,
    KIND_HOUR  = 2'd2,
    KIND_FIXED = 2'd3
  } volume_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLUME_UI    = 2'd0,
    REG_VOLUME_ALARM = 2'd1,
    REG_VOLUME_HOUR  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [VOL_W-1:0] ui;
    logic [VOL_W-1:0] alarm;
    logic [VOL_W-1:0] hour;
  } volumes_t;

  typedef struct packed {
    logic pin;
    logic busy_res;
    logic finished;
    logic accepted;
  } result_t;

endpackage

>>> hdl/ptb_ctrl.sv
module ptb_ctrl #(
  parameter int unsigned TONE_BITS = ptb_pkg::TONE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [2:0]                  opcode_i,
  input  logic [ptb_pkg::LEN_W-1:0]   length_ms_i,
  input  logic [TONE_BITS-1:0]        tone_i,
  input  logic [1:0]                  volume_kind_i,
  input  logic [ptb_pkg::PRIO_W-1:0]  priority_req_i,
  input  ptb_pkg::volumes_t           volumes_i,
  output ptb_pkg::result_t            res_o
);

  logic [ptb_pkg::PRIO_W-1:0] held_q, held_d;
  logic [ptb_pkg::LEN_W-1:0]  duration_q, duration_d;
  logic [ptb_pkg::LEN_W-1:0]  elapsed_q, elapsed_d;
  logic [ptb_pkg::PWM_W-1:0]  top_q, top_d;
  logic [ptb_pkg::PWM_W-1:0]  cmp_q, cmp_d;
  logic [ptb_pkg::PWM_W-1:0]  cnt_q, cnt_d;
  logic                       down_q, down_d;
  logic                       run_q, run_d;
  logic                       on_q, on_d;
  logic                       await_q, await_d;

  logic [ptb_pkg::VOL_W-1:0]  vol_set;
  logic [ptb_pkg::VOL_W-1:0]  vol;
  logic [2:0]                 shamt;
  logic [ptb_pkg::PWM_W-1:0]  new_top;
  logic [ptb_pkg::PWM_W-1:0]  cnt_dec;
  logic                       bottom;
  logic                       accepted;
  logic                       finished;

  always_comb begin
    case (ptb_pkg::volume_kind_e'(volume_kind_i))
      ptb_pkg::KIND_UI:    vol_set = volumes_i.ui;
      ptb_pkg::KIND_ALARM: vol_set = volumes_i.alarm;
      ptb_pkg::KIND_HOUR:  vol_set = volumes_i.hour;
      default:             vol_set = ptb_pkg::VOLUME_FIXED;
    endcase
  end

  assign vol     = vol_set - 8'd1;
  assign shamt   = ptb_pkg::SHIFT_BASE - vol[2:0];
  assign new_top = ptb_pkg::PWM_W'({tone_i, {ptb_pkg::TONE_SHIFT{1'b0}}});
  assign cnt_dec = (cnt_q != '0) ? cnt_q - 16'd1 : cnt_q;

  always_comb begin
    held_d     = held_q;
    duration_d = duration_q;
    elapsed_d  = elapsed_q;
    top_d      = top_q;
    cmp_d      = cmp_q;
    cnt_d      = cnt_q;
    down_d     = down_q;
    run_d      = run_q;
    on_d       = on_q;
    await_d    = await_q;
    accepted   = 1'b0;
    finished   = 1'b0;
    bottom     = 1'b0;

    unique case (ptb_pkg::opcode_e'(opcode_i)) inside
      ptb_pkg::OP_PLAY, ptb_pkg::OP_PAUSE, ptb_pkg::OP_STOP: begin
        if (priority_req_i >= held_q) begin
          accepted = 1'b1;
          if (opcode_i == ptb_pkg::OP_STOP) begin
            on_d       = 1'b0;
            run_d      = 1'b0;
            duration_d = '0;
            held_d     = '0;
          end else begin
            held_d     = priority_req_i;
            duration_d = length_ms_i;
            elapsed_d  = '0;
            if (opcode_i == ptb_pkg::OP_PAUSE) begin
              on_d  = 1'b0;
              run_d = 1'b0;
            end else if (vol <= ptb_pkg::VOLUME_MAX) begin
              // out-of-range volume leaves the timer untouched
              top_d   = new_top;
              cmp_d   = new_top - (new_top >> shamt);
              cnt_d   = '0;
              down_d  = 1'b0;
              run_d   = 1'b1;
              await_d = 1'b1;
            end
          end
        end
      end
      ptb_pkg::OP_MS_TICK: begin
        elapsed_d = elapsed_q + 8'd1;
        if (duration_q != '0 && elapsed_d >= duration_q) begin
          on_d       = 1'b0;
          run_d      = 1'b0;
          duration_d = '0;
          held_d     = '0;
          finished   = 1'b1;
        end
      end
      ptb_pkg::OP_TIMER_TICK: begin
        if (run_q) begin
          if (!down_q) begin
            if (cnt_q < top_q) begin
              cnt_d = cnt_q + 16'd1;
            end else begin
              down_d = 1'b1;
              cnt_d  = cnt_dec;
            end
          end else begin
            cnt_d = cnt_dec;
            if (cnt_dec == '0) begin
              down_d = 1'b0;
              bottom = 1'b1;
            end
          end
          // output comes on at the first bottom after a new tone
          if (bottom && await_q) begin
            on_d    = 1'b1;
            await_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o.pin      = on_d && run_d && (cnt_d > cmp_d);
  assign res_o.busy_res = (duration_d != '0);
  assign res_o.finished = finished;
  assign res_o.accepted = accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      duration_q <= '0;
      elapsed_q  <= '0;
      top_q      <= ptb_pkg::PERIOD_RESET;
      cmp_q      <= ptb_pkg::COMPARE_RESET;
      cnt_q      <= '0;
      down_q     <= 1'b0;
      run_q      <= 1'b0;
      on_q       <= 1'b0;
      await_q    <= 1'b0;
    end else if (fire_i) begin
      held_q     <= held_d;
      duration_q <= duration_d;
      elapsed_q  <= elapsed_d;
      top_q      <= top_d;
      cmp_q      <= cmp_d;
      cnt_q      <= cnt_d;
      down_q     <= down_d;
      run_q      <= run_d;
      on_q       <= on_d;
      await_q    <= await_d;
    end
  end

  // counter never climbs past the top it was loaded with
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= top_q)
    else $error("pwm counter above top");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.finished) |-> !res_o.busy_res)
    else $error("busy still set on expiry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.finished) |=> (held_q == '0 && !run_q))
    else $error("expiry did not release priority or stop timer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && res_o.accepted && opcode_i != ptb_pkg::OP_STOP) |=> (elapsed_q == '0))
    else $error("elapsed not cleared by accepted request");

endmodule

>>> hdl/priority_tone_buzzer.sv
// channel | dir | handshake               | payload
// input   | in  | in_valid_i/in_ready_o   | opcode, length_ms, tone, volume_kind, priority_req
// result  | out | out_valid_o/out_ready_i | pin, busy_res, finished, accepted
// config  | in  | cfg_we_i                | cfg_index_i, cfg_wdata_i
//
// one transaction per clock sustained while results are taken; a result passes from its input
// transaction through the input register, the step logic and the result register
// the input register can take a new input transaction while the previous result is stalled
// rst_ni is asynchronous active low and loads the volume registers with two
// a stalled result holds the input register; in_ready_o drops only when both are full
module priority_tone_buzzer #(
  parameter int unsigned TONE_BITS = ptb_pkg::TONE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     opcode_i,
  input  logic [ptb_pkg::LEN_W-1:0]      length_ms_i,
  input  logic [TONE_BITS-1:0]           tone_i,
  input  logic [1:0]                     volume_kind_i,
  input  logic [ptb_pkg::PRIO_W-1:0]     priority_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           pin_o,
  output logic                           busy_res_o,
  output logic                           finished_o,
  output logic                           accepted_o,
  input  logic                           cfg_we_i,
  input  logic [ptb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ptb_pkg::VOL_W-1:0]      cfg_wdata_i
);

  logic                          in_valid_q;
  logic [2:0]                    opcode_q;
  logic [ptb_pkg::LEN_W-1:0]     length_ms_q;
  logic [TONE_BITS-1:0]          tone_q;
  logic [1:0]                    volume_kind_q;
  logic [ptb_pkg::PRIO_W-1:0]    priority_req_q;
  logic                          out_valid_q;
  ptb_pkg::result_t              res_q;
  ptb_pkg::result_t              res;
  ptb_pkg::volumes_t             vol_q;
  logic                          fire;
  logic                          in_take;

  assign fire       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || fire;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q       <= opcode_i;
      length_ms_q    <= length_ms_i;
      tone_q         <= tone_i;
      volume_kind_q  <= volume_kind_i;
      priority_req_q <= priority_req_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q.ui    <= ptb_pkg::VOLUME_RESET;
      vol_q.alarm <= ptb_pkg::VOLUME_RESET;
      vol_q.hour  <= ptb_pkg::VOLUME_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptb_pkg::REG_VOLUME_UI:    vol_q.ui    <= cfg_wdata_i;
        ptb_pkg::REG_VOLUME_ALARM: vol_q.alarm <= cfg_wdata_i;
        ptb_pkg::REG_VOLUME_HOUR:  vol_q.hour  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  ptb_ctrl #(
    .TONE_BITS (TONE_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .opcode_i       (opcode_q),
    .length_ms_i    (length_ms_q),
    .tone_i         (tone_q),
    .volume_kind_i  (volume_kind_q),
    .priority_req_i (priority_req_q),
    .volumes_i      (vol_q),
    .res_o          (res)
  );

  assign out_valid_o = out_valid_q;
  assign pin_o       = res_q.pin;
  assign busy_res_o  = res_q.busy_res;
  assign finished_o  = res_q.finished;
  assign accepted_o  = res_q.accepted;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import ptb_pkg::*;

  localparam int unsigned TB_TONE_W      = TONE_BITS_DEF;
  localparam logic [2:0]  OP_RESERVED_LO = 3'd5;
  localparam logic [2:0]  OP_RESERVED_HI = 3'd7;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 1700;
  localparam int unsigned NUM_PHASES     = 6;

  class buzzer_scoreboard;
    logic [VOL_W-1:0]  ui_level, alarm_level, hour_level;
    logic [PRIO_W-1:0] held_prio;
    logic [LEN_W-1:0]  duration, elapsed;
    logic [PWM_W-1:0]  period_top, compare_lvl, pwm_cnt;
    logic              cnt_down, tmr_run, out_on, await_bot;
    result_t           pending_results[$];
    int unsigned       n_errors, n_checked, n_finished, n_pin_high, n_accepted;

    function new();
      ui_level    = VOLUME_RESET;
      alarm_level = VOLUME_RESET;
      hour_level  = VOLUME_RESET;
      held_prio   = '0;
      duration    = '0;
      elapsed     = '0;
      period_top  = PERIOD_RESET;
      compare_lvl = COMPARE_RESET;
      pwm_cnt     = '0;
      cnt_down    = 1'b0;
      tmr_run     = 1'b0;
      out_on      = 1'b0;
      await_bot   = 1'b0;
    endfunction

    function void set_volume(cfg_reg_e idx, logic [VOL_W-1:0] v);
      case (idx)
        REG_VOLUME_UI:    ui_level = v;
        REG_VOLUME_ALARM: alarm_level = v;
        REG_VOLUME_HOUR:  hour_level = v;
        default: ;
      endcase
    endfunction

    function void halt_tone();
      out_on    = 1'b0;
      tmr_run   = 1'b0;
      duration  = '0;
      held_prio = '0;
    endfunction

    // up/down counter, output gets enabled on the first bottom after a play
    function void advance_pwm();
      logic at_bottom;
      at_bottom = 1'b0;
      if (!cnt_down) begin
        if (pwm_cnt < period_top) begin
          pwm_cnt++;
        end else begin
          cnt_down = 1'b1;
          if (pwm_cnt > 0) pwm_cnt--;
        end
      end else begin
        if (pwm_cnt > 0) pwm_cnt--;
        if (pwm_cnt == 0) begin
          cnt_down  = 1'b0;
          at_bottom = 1'b1;
        end
      end
      if (at_bottom && await_bot) begin
        out_on    = 1'b1;
        await_bot = 1'b0;
      end
    endfunction

    function void note_request(logic [2:0] op, logic [LEN_W-1:0] len,
                               logic [TB_TONE_W-1:0] tone, logic [1:0] kind,
                               logic [PRIO_W-1:0] prio);
      result_t          r;
      logic [VOL_W-1:0] vol;
      logic [PWM_W-1:0] top;
      r = '0;
      if (op == OP_PLAY || op == OP_PAUSE || op == OP_STOP) begin
        if (prio >= held_prio) begin
          r.accepted = 1'b1;
          if (op == OP_STOP) begin
            halt_tone();
          end else begin
            held_prio = prio;
            duration  = len;
            elapsed   = '0;
            if (op == OP_PAUSE) begin
              out_on  = 1'b0;
              tmr_run = 1'b0;
            end else begin
              case (kind)
                KIND_UI:    vol = ui_level;
                KIND_ALARM: vol = alarm_level;
                KIND_HOUR:  vol = hour_level;
                default:    vol = VOLUME_FIXED;
              endcase
              vol = vol - 8'd1;
              // out-of-range volume keeps the running tone untouched
              if (vol <= VOLUME_MAX) begin
                top         = PWM_W'(tone) << TONE_SHIFT;
                period_top  = top;
                compare_lvl = top - (top >> (SHIFT_BASE - vol[2:0]));
                pwm_cnt     = '0;
                cnt_down    = 1'b0;
                tmr_run     = 1'b1;
                await_bot   = 1'b1;
              end
            end
          end
        end
      end else if (op == OP_MS_TICK) begin
        elapsed++;
        if (duration != 0 && elapsed >= duration) begin
          halt_tone();
          r.finished = 1'b1;
        end
      end else if (op == OP_TIMER_TICK) begin
        if (tmr_run) advance_pwm();
      end
      r.pin      = out_on && tmr_run && (pwm_cnt > compare_lvl);
      r.busy_res = (duration != 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   names[4];
      names = '{"pin", "busy_res", "finished", "accepted"};
      if (pending_results.size() == 0) begin
        n_errors++;
        $display("%0t: result with nothing expected, actual %b", $time, got);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      for (int i = 0; i < 4; i++) begin
        if (got[3-i] !== want[3-i]) begin
          n_errors++;
          $display("%0t: %s mismatch, expected %b actual %b",
                   $time, names[i], want[3-i], got[3-i]);
        end
      end
      if (got.finished) n_finished++;
      if (got.pin) n_pin_high++;
      if (got.accepted) n_accepted++;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [2:0]            opcode_i;
  logic [LEN_W-1:0]      length_ms_i;
  logic [TB_TONE_W-1:0]  tone_i;
  logic [1:0]            volume_kind_i;
  logic [PRIO_W-1:0]     priority_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  pin_o;
  logic                  busy_res_o;
  logic                  finished_o;
  logic                  accepted_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [VOL_W-1:0]      cfg_wdata_i;

  buzzer_scoreboard sb;
  int unsigned      n_sent;
  int unsigned      in_steady_left;
  int unsigned      stall_left;
  int unsigned      ready_steady_left;
  int unsigned      quiet_cycles;

  priority_tone_buzzer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .length_ms_i    (length_ms_i),
    .tone_i         (tone_i),
    .volume_kind_i  (volume_kind_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pin_o          (pin_o),
    .busy_res_o     (busy_res_o),
    .finished_o     (finished_o),
    .accepted_o     (accepted_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // small tones so the pwm turns around within a burst of timer ticks
  function automatic logic [TB_TONE_W-1:0] pick_tone();
    if ($urandom_range(0, 99) < 80) return TB_TONE_W'($urandom_range(0, 6));
    return TB_TONE_W'($urandom_range(0, (1 << TB_TONE_W) - 1));
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return '0;
    if (roll < 80) return LEN_W'($urandom_range(1, 6));
    return LEN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority();
    if ($urandom_range(0, 99) < 80) return PRIO_W'($urandom_range(sb.held_prio, 7));
    return PRIO_W'($urandom_range(0, 7));
  endfunction

  task automatic send_item(input logic [2:0] op, input logic [LEN_W-1:0] len,
                           input logic [TB_TONE_W-1:0] tone, input logic [1:0] kind,
                           input logic [PRIO_W-1:0] prio);
    int unsigned gap;
    gap = 0;
    if (in_steady_left > 0) begin
      in_steady_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      in_steady_left = $urandom_range(20, 80);
    end else begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    opcode_i       = op;
    length_ms_i    = len;
    tone_i         = tone;
    volume_kind_i  = kind;
    priority_req_i = prio;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, len, tone, kind, prio);
    if (op < OP_RESERVED_LO) n_sent++;
  endtask

  task automatic send_tick(input logic [2:0] op);
    send_item(op, LEN_W'($urandom_range(0, 255)), TB_TONE_W'($urandom),
              2'($urandom_range(0, 3)), PRIO_W'($urandom_range(0, 7)));
  endtask

  // timer ticks with the odd ms tick or stop thrown in
  task automatic tick_burst(input int unsigned n);
    int unsigned roll;
    for (int unsigned i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_tick(OP_MS_TICK);
      end else if (roll < 7) begin
        send_item(OP_STOP, pick_length(), pick_tone(), 2'($urandom_range(0, 3)),
                  pick_priority());
      end else begin
        send_tick(OP_TIMER_TICK);
      end
    end
  endtask

  task automatic play_sequence();
    int unsigned roll;
    int unsigned span;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      // play, then half the time a burst long enough to see the pin toggle for a small tone
      send_item(OP_PLAY, pick_length(), pick_tone(), 2'($urandom_range(0, 3)),
                pick_priority());
      span = 2 * int'(sb.period_top) + 30;
      if (span > 120) span = 120;
      if ($urandom_range(0, 1)) tick_burst($urandom_range(span / 2, span));
      else tick_burst($urandom_range(0, 10));
    end else if (roll < 70) begin
      repeat ($urandom_range(1, 8)) send_tick(OP_MS_TICK);
      tick_burst($urandom_range(0, 10));
    end else if (roll < 82) begin
      send_item((roll < 76) ? OP_PAUSE : OP_STOP, pick_length(), pick_tone(),
                2'($urandom_range(0, 3)), pick_priority());
    end else if (roll < 90) begin
      repeat ($urandom_range(1, 4)) begin
        send_item(3'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 255)),
                  TB_TONE_W'($urandom), 2'($urandom_range(0, 3)),
                  PRIO_W'($urandom_range(0, 7)));
      end
    end else begin
      // interrupted play: followed by a stop or another play at a random priority
      send_item(OP_PLAY, pick_length(), pick_tone(), 2'($urandom_range(0, 3)),
                pick_priority());
      send_item($urandom_range(0, 1) ? OP_STOP : OP_PLAY, pick_length(), pick_tone(),
                2'($urandom_range(0, 3)), PRIO_W'($urandom_range(0, 7)));
      tick_burst($urandom_range(0, 20));
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_volume(input cfg_reg_e idx, input logic [VOL_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_volume(idx, v);
  endtask

  task automatic program_volumes(input int phase);
    logic [VOL_W-1:0] v[3];
    case (phase)
      0: v = '{8'd1, 8'd3, 8'd2};
      1: v = '{8'd0, 8'd255, 8'd4};
      2: v = '{8'd3, 8'd1, 8'd255};
      default: begin
        foreach (v[i]) begin
          if ($urandom_range(0, 99) < 85) v[i] = VOL_W'($urandom_range(0, 4));
          else v[i] = VOL_W'($urandom_range(0, 255));
        end
      end
    endcase
    write_volume(REG_VOLUME_UI, v[0]);
    write_volume(REG_VOLUME_ALARM, v[1]);
    write_volume(REG_VOLUME_HOUR, v[2]);
  endtask

  task automatic directed_items();
    // zero top: counter sits at zero and bottoms every other tick
    send_item(OP_PLAY, '0, '0, KIND_UI, '0);
    repeat (3) send_tick(OP_TIMER_TICK);
    send_item(OP_PLAY, '1, '1, KIND_ALARM, '1);
    send_item(OP_STOP, '0, '0, KIND_UI, '0);
    send_tick(OP_MS_TICK);
    send_item(OP_STOP, '0, '0, KIND_UI, '1);
    send_tick(OP_TIMER_TICK);
    send_item(OP_PLAY, 8'd2, 13'd4, KIND_FIXED, 3'd3);
    send_item(OP_PAUSE, 8'd9, 13'd4, KIND_HOUR, 3'd2);
    repeat (2) send_tick(OP_MS_TICK);
    send_item(OP_PAUSE, 8'd1, '0, KIND_HOUR, 3'd5);
    send_tick(OP_MS_TICK);
    for (int op = OP_RESERVED_LO; op <= OP_RESERVED_HI; op++) begin
      send_item(3'(op), '1, '1, '1, '1);
    end
    send_item(OP_PLAY, '0, 13'd1, KIND_HOUR, '0);
    repeat (3) send_tick(OP_TIMER_TICK);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (ready_steady_left > 0) begin
          ready_steady_left--;
        end else if ($urandom_range(0, 99) < 3) begin
          ready_steady_left = $urandom_range(20, 80);
        end else begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result({pin_o, busy_res_o, finished_o, accepted_o});
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned target;
    sb                = new();
    n_sent            = 0;
    in_steady_left    = 0;
    stall_left        = 0;
    ready_steady_left = 0;
    quiet_cycles      = 0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    opcode_i          = OP_PLAY;
    length_ms_i       = '0;
    tone_i            = '0;
    volume_kind_i     = KIND_UI;
    priority_req_i    = '0;
    out_ready_i       = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_VOLUME_UI;
    cfg_wdata_i       = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    directed_items();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      program_volumes(phase);
      target = n_sent + RANDOM_ITEMS / NUM_PHASES;
      while (n_sent < target) play_sequence();
    end
    drain();
    repeat (10) @(posedge clk_i);

    $display("%0d transactions over %0d volume settings, %0d results checked",
             n_sent, NUM_PHASES + 1, sb.n_checked);
    $display("%0d requests accepted, %0d expiries, %0d results with pin high, %0d errors",
             sb.n_accepted, sb.n_finished, sb.n_pin_high, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
